// ----- rtl/mqsb_pkg.sv -----
// Shared constants, codes and types for the multi-queue shared buffer.
// Used by the interfaces and by every module of the block; no dependencies.
package mqsb_pkg;

    // Storage geometry.
    localparam int DEPTH      = 64;
    localparam int MAX_QUEUES = 8;
    localparam int DATA_WIDTH = 32;

    // Pointer widths: a slot index, and a pointer that can also hold "none".
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int QIDX_W = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

    localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(DEPTH);

    // Fixed field widths of the channels.
    localparam int QID_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int NUMQ_W   = 4;

    localparam logic [NUMQ_W-1:0] NUMQ_RESET = NUMQ_W'(8);

    // Request types.
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // Classification done by the front end.
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENQ     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEQ     = 2'd2;

    // Decoupling queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [QIDX_W-1:0]     qsel;
        logic [DATA_WIDTH-1:0] value;
    } work_item_t;

endpackage

// ----- rtl/mqsb_ifs.sv -----
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on mqsb_pkg for field widths.
interface mqsb_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [mqsb_pkg::QID_W-1:0]            queue_id;
    logic signed [mqsb_pkg::WORD_W-1:0]    value;

    modport source (output valid, req_type, queue_id, value, input ready);
    modport sink   (input valid, req_type, queue_id, value, output ready);
endinterface

interface mqsb_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [mqsb_pkg::STATUS_W-1:0]         status;
    logic signed [mqsb_pkg::WORD_W-1:0]    data_out;

    modport source (output valid, status, data_out, input ready);
    modport sink   (input valid, status, data_out, output ready);
endinterface

interface mqsb_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mqsb_pkg::NUMQ_W-1:0]           data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/mqsb_front.sv -----
// Front end: holds the queue-count register, accepts requests and classifies them.
// Depends on mqsb_pkg and the channel interfaces in mqsb_ifs.sv.
module mqsb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mqsb_req_if.sink              req,
    mqsb_cfg_if.sink              cfg,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mqsb_pkg::work_item_t  push_item
);

    logic [mqsb_pkg::NUMQ_W-1:0] num_queues_reg;
    logic                        bad_queue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_queues_reg <= mqsb_pkg::NUMQ_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            num_queues_reg <= cfg.data;
        end
    end

    assign cfg.ready = 1'b1;

    // A queue number is rejected against both the register and the built-in count.
    assign bad_queue = (int'(req.queue_id) >= int'(num_queues_reg)) ||
                       (int'(req.queue_id) >= mqsb_pkg::MAX_QUEUES);

    always_comb
    begin
        if (bad_queue)
        begin
            push_item.kind = mqsb_pkg::KIND_INVALID;
        end
        else if (req.req_type == mqsb_pkg::REQ_DEQ)
        begin
            push_item.kind = mqsb_pkg::KIND_DEQ;
        end
        else
        begin
            push_item.kind = mqsb_pkg::KIND_ENQ;
        end
        push_item.qsel  = mqsb_pkg::QIDX_W'(req.queue_id);
        push_item.value = mqsb_pkg::DATA_WIDTH'($unsigned(req.value));
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

// ----- rtl/mqsb_queue.sv -----
// Short FIFO of classified work items between the front and back ends.
// Depends on mqsb_pkg for the item type and depth.
module mqsb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  mqsb_pkg::work_item_t  push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output mqsb_pkg::work_item_t  pop_item
);

    mqsb_pkg::work_item_t          entry_reg [mqsb_pkg::QUEUE_DEPTH];
    logic [mqsb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mqsb_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [mqsb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mqsb_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [mqsb_pkg::QCNT_W-1:0]   count_reg;
    logic [mqsb_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != mqsb_pkg::QCNT_W'(mqsb_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mqsb_pkg::QPTR_W'(mqsb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + mqsb_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mqsb_pkg::QPTR_W'(mqsb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + mqsb_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + mqsb_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - mqsb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/mqsb_back.sv -----
// Back end: queue heads and tails, free list, link and data memories, result register.
// Depends on mqsb_pkg and the response interface in mqsb_ifs.sv.
module mqsb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  mqsb_pkg::work_item_t  pop_item,
    mqsb_rsp_if.source            rsp
);

    localparam logic BK_IDLE = 1'b0;
    localparam logic BK_DONE = 1'b1;

    logic state_reg;
    logic state_next;

    // Pointer state.
    logic [mqsb_pkg::PTR_W-1:0] free_head_reg;
    logic [mqsb_pkg::PTR_W-1:0] head_reg [mqsb_pkg::MAX_QUEUES];
    logic [mqsb_pkg::IDX_W-1:0] tail_reg [mqsb_pkg::MAX_QUEUES];

    // Memories; a link entry that was never written reads as its successor index.
    logic [mqsb_pkg::PTR_W-1:0]      link_mem [mqsb_pkg::DEPTH];
    logic [mqsb_pkg::DATA_WIDTH-1:0] data_mem [mqsb_pkg::DEPTH];
    logic [mqsb_pkg::DEPTH-1:0]      link_vld_reg;

    // Item in flight.
    logic [mqsb_pkg::KIND_W-1:0]   cur_kind_reg;
    logic [mqsb_pkg::QIDX_W-1:0]   cur_qsel_reg;
    logic [mqsb_pkg::STATUS_W-1:0] cur_status_reg;
    logic [mqsb_pkg::IDX_W-1:0]    cur_slot_reg;
    logic [mqsb_pkg::IDX_W-1:0]    cur_tail_reg;
    logic                          cur_was_empty_reg;
    logic [mqsb_pkg::PTR_W-1:0]      link_rd_reg;
    logic                            link_rd_vld_reg;
    logic [mqsb_pkg::DATA_WIDTH-1:0] data_rd_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [mqsb_pkg::STATUS_W-1:0] out_status_reg;
    logic [mqsb_pkg::WORD_W-1:0]   out_data_reg;

    logic [mqsb_pkg::PTR_W-1:0]    head_sel;
    logic [mqsb_pkg::STATUS_W-1:0] start_status;
    logic [mqsb_pkg::IDX_W-1:0]    rd_addr;
    logic                          start;
    logic                          start_ok;
    logic                          enq_write;
    logic                          finish;
    logic                          finish_ok;
    logic                          link_fix_en;
    logic [mqsb_pkg::IDX_W-1:0]    link_fix_addr;
    logic [mqsb_pkg::PTR_W-1:0]    link_fix_data;
    logic                          link_wr_en;
    logic [mqsb_pkg::IDX_W-1:0]    link_wr_addr;
    logic [mqsb_pkg::PTR_W-1:0]    link_wr_data;
    logic [mqsb_pkg::PTR_W-1:0]    link_val;

    function automatic logic is_none(input logic [mqsb_pkg::PTR_W-1:0] p);
        return (p >= mqsb_pkg::NONE_PTR);
    endfunction

    // Idle state: look up the pointers and start the memory reads.
    assign head_sel  = head_reg[pop_item.qsel];
    assign pop_ready = (state_reg == BK_IDLE);
    assign start     = pop_valid && pop_ready;

    always_comb
    begin
        unique case (pop_item.kind)
            mqsb_pkg::KIND_ENQ:
            begin
                start_status = is_none(free_head_reg) ? mqsb_pkg::ST_FULL : mqsb_pkg::ST_OK;
                rd_addr      = free_head_reg[mqsb_pkg::IDX_W-1:0];
            end
            mqsb_pkg::KIND_DEQ:
            begin
                start_status = is_none(head_sel) ? mqsb_pkg::ST_EMPTY : mqsb_pkg::ST_OK;
                rd_addr      = head_sel[mqsb_pkg::IDX_W-1:0];
            end
            default:
            begin
                start_status = mqsb_pkg::ST_INVALID;
                rd_addr      = free_head_reg[mqsb_pkg::IDX_W-1:0];
            end
        endcase
    end

    assign start_ok  = start && (start_status == mqsb_pkg::ST_OK);
    assign enq_write = start_ok && (pop_item.kind == mqsb_pkg::KIND_ENQ);

    // Done state: commit pointer updates once the result register can take the result.
    assign finish    = (state_reg == BK_DONE) && (!out_valid_reg || rsp.ready);
    assign finish_ok = finish && (cur_status_reg == mqsb_pkg::ST_OK);

    assign link_val = link_rd_vld_reg ? link_rd_reg :
                      mqsb_pkg::PTR_W'(cur_slot_reg) + mqsb_pkg::PTR_W'(1);

    always_comb
    begin
        link_fix_en   = 1'b0;
        link_fix_addr = cur_slot_reg;
        link_fix_data = free_head_reg;
        if (finish_ok)
        begin
            if (cur_kind_reg == mqsb_pkg::KIND_DEQ)
            begin
                link_fix_en = 1'b1;
            end
            else if (!cur_was_empty_reg)
            begin
                link_fix_en   = 1'b1;
                link_fix_addr = cur_tail_reg;
                link_fix_data = mqsb_pkg::PTR_W'(cur_slot_reg);
            end
        end
    end

    // The two write sources sit in different cycles of the sequence.
    assign link_wr_en   = enq_write || link_fix_en;
    assign link_wr_addr = enq_write ? rd_addr : link_fix_addr;
    assign link_wr_data = enq_write ? mqsb_pkg::NONE_PTR : link_fix_data;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (finish)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            free_head_reg <= '0;
            link_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < mqsb_pkg::MAX_QUEUES; i++)
            begin
                head_reg[i] <= mqsb_pkg::NONE_PTR;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (link_wr_en)
            begin
                link_vld_reg[link_wr_addr] <= 1'b1;
            end
            if (finish_ok)
            begin
                if (cur_kind_reg == mqsb_pkg::KIND_DEQ)
                begin
                    head_reg[cur_qsel_reg] <= link_val;
                    free_head_reg          <= mqsb_pkg::PTR_W'(cur_slot_reg);
                end
                else
                begin
                    free_head_reg <= link_val;
                    if (cur_was_empty_reg)
                    begin
                        head_reg[cur_qsel_reg] <= mqsb_pkg::PTR_W'(cur_slot_reg);
                    end
                end
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_ok && (cur_kind_reg == mqsb_pkg::KIND_ENQ))
        begin
            tail_reg[cur_qsel_reg] <= cur_slot_reg;
        end
        if (start)
        begin
            cur_kind_reg      <= pop_item.kind;
            cur_qsel_reg      <= pop_item.qsel;
            cur_status_reg    <= start_status;
            cur_slot_reg      <= rd_addr;
            cur_tail_reg      <= tail_reg[pop_item.qsel];
            cur_was_empty_reg <= is_none(head_sel);
        end
        if (finish)
        begin
            out_status_reg <= cur_status_reg;
            if (finish_ok && (cur_kind_reg == mqsb_pkg::KIND_DEQ))
            begin
                out_data_reg <= mqsb_pkg::WORD_W'(data_rd_reg);
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    // Link memory: read-first, so a start that rewrites its own slot sees the old link.
    always_ff @(posedge clk)
    begin
        if (start_ok)
        begin
            link_rd_reg     <= link_mem[rd_addr];
            link_rd_vld_reg <= link_vld_reg[rd_addr];
        end
        if (link_wr_en)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_ok)
        begin
            data_rd_reg <= data_mem[rd_addr];
        end
        if (enq_write)
        begin
            data_mem[rd_addr] <= pop_item.value;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.data_out = $signed(out_data_reg);

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != mqsb_pkg::ST_OK) |-> (out_data_reg == '0))
        else $error("failed request carries nonzero data");

    a_done_stalls_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DONE) |=> (state_reg == BK_IDLE) || out_valid_reg)
        else $error("back end held without a pending result");

    a_deq_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        finish_ok && (cur_kind_reg == mqsb_pkg::KIND_DEQ)
        |=> (free_head_reg == mqsb_pkg::PTR_W'($past(cur_slot_reg))))
        else $error("dequeued slot not pushed onto the free list");

    a_enq_head_set: assert property (@(posedge clk) disable iff (!rst_n)
        finish_ok && (cur_kind_reg == mqsb_pkg::KIND_ENQ)
        |=> !is_none(head_reg[$past(cur_qsel_reg)]))
        else $error("queue empty right after a successful enqueue");

endmodule

// ----- rtl/multi_queue_shared_buffer_top.sv -----
// Top level of the multi-queue shared buffer.
// Depends on mqsb_pkg, mqsb_ifs.sv, mqsb_front, mqsb_queue and mqsb_back.
//
// Up to MAX_QUEUES FIFO queues share one store of DEPTH data slots, kept as linked
// lists with unused slots chained on a common free list. Each request transaction
// (enqueue a value, or dequeue from a queue) produces exactly one response
// transaction with a status (ok, buffer full, queue empty, invalid queue number)
// and, for a successful dequeue, the value; otherwise the data is zero. The front
// end checks the queue number against the num_queues register and passes the
// classified request through a two-entry queue to the back end, so requests keep
// being accepted while a response waits to be taken, until that queue is full. The
// back end takes every request, whatever its outcome, through an idle state and a
// done state: in the idle state it reads the queue pointers and the link memory
// (and writes the data of an enqueue); in the done state, once the result register
// can take the result, it uses the link it read to update the free list and the
// queue pointers, which the next request depends on. So it takes no new request
// until the previous one is done, and the response is registered. The link memory
// starts out as a chain over all slots through per-entry valid bits cleared at
// reset, so no clearing pass is needed. The num_queues register is written through
// the cfg channel and should only be changed while no request is in flight; queue
// contents survive a change, and queues from the new count up become unreachable.
module multi_queue_shared_buffer_top (
    input  logic        clk,
    input  logic        rst_n,
    mqsb_req_if.sink    req,
    mqsb_rsp_if.source  rsp,
    mqsb_cfg_if.sink    cfg
);

    // Front end to decoupling queue.
    logic                  push_valid;
    logic                  push_ready;
    mqsb_pkg::work_item_t  push_item;

    // Decoupling queue to back end.
    logic                  pop_valid;
    logic                  pop_ready;
    mqsb_pkg::work_item_t  pop_item;

    // Accepts request transactions and configuration writes, and classifies requests.
    mqsb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Until full, lets the front end accept while the back end is busy or stalled.
    mqsb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Carries out each request against the pointers and memories.
    mqsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .rsp       (rsp)
    );

endmodule
